/* design/brp_pkg.sv */
// Shared types, codes and constants for the HTTP byte range parser.
`timescale 1ns / 1ps

package brp_pkg;

    localparam int RANGE_W = 48;
    localparam int SIZE_W  = 49;
    localparam int CFG_W   = 48;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_Y     = 8'h79;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [3:0] {
        ERR_OK          = 4'd0,
        ERR_PREFIX      = 4'd1,
        ERR_NO_DASH     = 4'd2,
        ERR_START_NODIG = 4'd3,
        ERR_START_BAD   = 4'd4,
        ERR_END_NODIG   = 4'd5,
        ERR_END_BAD     = 4'd6,
        ERR_ORDER       = 4'd7,
        ERR_OVER_MAX    = 4'd8,
        ERR_TOO_MANY    = 4'd9
    } t_err;

    typedef enum logic {
        PH_START = 1'b0,
        PH_END   = 1'b1
    } t_phase;

    typedef struct packed {
        logic nonempty;
        logic sdigit;
        logic sbad;
        logic sbadnodig;
        logic edigit;
    } t_flags;

    typedef struct packed {
        logic                is_status;
        logic [RANGE_W-1:0]  range_start;
        logic [RANGE_W-1:0]  range_end;
        logic [SIZE_W-1:0]   range_size;
        t_err                status_code;
        logic                last_result;
    } t_result;

    // Results made by one character: a range first, then the status.
    typedef struct packed {
        logic    rng_valid;
        logic    sts_valid;
        t_result rng;
        t_result sts;
    } t_push;

    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_B;
            3'd1:    ch = CH_Y;
            3'd2:    ch = CH_T;
            3'd3:    ch = CH_E;
            3'd4:    ch = CH_S;
            default: ch = CH_EQ;
        endcase
        return ch;
    endfunction

endpackage

/* design/brp_parse.sv */
// Per-character header state and the range checks that close a token.
`timescale 1ns / 1ps

module brp_parse
    import brp_pkg::*;
#(
    parameter int OFFSET_BITS = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_char,
    input  logic             i_last,
    input  logic [CFG_W-1:0] i_max_size,
    output t_push            o_push
);

    localparam int OB = OFFSET_BITS;
    localparam int TW = OFFSET_BITS + 2;
    localparam int PW = OFFSET_BITS + 4;
    localparam logic [OB-1:0] OFF_MASK = {OB{1'b1}};

    logic [2:0]    r_pos,   n_pos;
    t_phase        r_phase, n_phase;
    logic [OB-1:0] r_start, n_start;
    logic [OB-1:0] r_end,   n_end;
    t_flags        r_flags, n_flags;
    t_err          r_err,   n_err;
    logic [TW-1:0] r_total, n_total;

    logic [OB-1:0] max_m;
    logic [TW-1:0] max_x3;
    logic          digit;
    logic [OB-1:0] acc_sel;
    logic [PW-1:0] acc_prod;
    logic [OB-1:0] acc_sat;
    logic          tok_end;
    logic [OB-1:0] tok_s;
    logic [OB-1:0] tok_e;
    logic [OB:0]   tok_sz;
    t_err          sts_code;

    assign max_m  = OB'(i_max_size);
    assign max_x3 = (TW'(max_m) << 1) + TW'(max_m);
    assign digit  = i_char inside {[CH_0:CH_9]};

    // One shared times-ten-plus-digit unit, saturating at the offset range.
    assign acc_sel  = (r_phase == PH_END) ? r_end : r_start;
    assign acc_prod = (PW'(acc_sel) << 3) + (PW'(acc_sel) << 1)
                    + PW'(4'(i_char - CH_0));
    assign acc_sat  = (acc_prod > PW'(OFF_MASK)) ? OFF_MASK : OB'(acc_prod);

    always_comb begin
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_start  = r_start;
        n_end    = r_end;
        n_flags  = r_flags;
        n_err    = r_err;
        n_total  = r_total;
        tok_end  = 1'b0;
        tok_s    = '0;
        tok_e    = '0;
        tok_sz   = '0;
        sts_code = ERR_OK;
        o_push   = '0;

        if (i_fire) begin
            if (r_err == ERR_OK) begin
                if (r_pos < PREFIX_LEN) begin
                    if (i_char == prefix_char(r_pos)) begin
                        n_pos = r_pos + 3'd1;
                    end else begin
                        n_err = ERR_PREFIX;
                    end
                end else if (i_char == CH_COMMA) begin
                    tok_end = 1'b1;
                end else begin
                    n_flags.nonempty = 1'b1;
                    if (r_phase == PH_START) begin
                        if (digit) begin
                            n_start        = acc_sat;
                            n_flags.sdigit = 1'b1;
                        end else if (i_char == CH_DASH) begin
                            n_phase = PH_END;
                            if (r_flags.sbad) begin
                                n_err = r_flags.sbadnodig ? ERR_START_NODIG : ERR_START_BAD;
                            end
                        end else if (!r_flags.sbad) begin
                            n_flags.sbad = 1'b1;
                            if (!r_flags.sdigit) begin
                                n_flags.sbadnodig = 1'b1;
                            end
                        end
                    end else begin
                        if (digit) begin
                            n_end          = acc_sat;
                            n_flags.edigit = 1'b1;
                        end else begin
                            n_err = r_flags.edigit ? ERR_END_BAD : ERR_END_NODIG;
                        end
                    end
                end

                if (i_last && n_err == ERR_OK) begin
                    if (n_pos < PREFIX_LEN) begin
                        n_err = ERR_PREFIX;
                    end else begin
                        tok_end = 1'b1;
                    end
                end

                // Close the token: checks run as order, bound, then total.
                if (tok_end) begin
                    if (n_flags.nonempty) begin
                        if (n_phase == PH_START) begin
                            n_err = ERR_NO_DASH;
                        end else begin
                            tok_s  = n_start;
                            tok_e  = n_flags.edigit ? n_end : (max_m - OB'(1));
                            tok_sz = (OB + 1)'(tok_e) - (OB + 1)'(tok_s) + (OB + 1)'(1);
                            if (tok_s > tok_e) begin
                                n_err = ERR_ORDER;
                            end else if (tok_e > max_m) begin
                                n_err = ERR_OVER_MAX;
                            end else if (r_total > max_x3) begin
                                n_err = ERR_TOO_MANY;
                            end else begin
                                n_total                = r_total + TW'(tok_sz);
                                o_push.rng_valid       = 1'b1;
                                o_push.rng.range_start = RANGE_W'(tok_s);
                                o_push.rng.range_end   = RANGE_W'(tok_e);
                                o_push.rng.range_size  = SIZE_W'(tok_sz);
                            end
                        end
                    end
                    n_phase = PH_START;
                    n_start = '0;
                    n_end   = '0;
                    n_flags = '0;
                end
            end

            if (i_last) begin
                sts_code                = n_err;
                o_push.sts_valid        = 1'b1;
                o_push.sts.is_status    = 1'b1;
                o_push.sts.status_code  = sts_code;
                o_push.sts.last_result  = 1'b1;
                n_pos   = '0;
                n_phase = PH_START;
                n_start = '0;
                n_end   = '0;
                n_flags = '0;
                n_err   = ERR_OK;
                n_total = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= PH_START;
            r_start <= '0;
            r_end   <= '0;
            r_flags <= '0;
            r_err   <= ERR_OK;
            r_total <= '0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_start <= n_start;
            r_end   <= n_end;
            r_flags <= n_flags;
            r_err   <= n_err;
            r_total <= n_total;
        end
    end

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.sts_valid |=> (r_err == ERR_OK && r_pos == 3'd0 && r_total == '0))
        else $error("header state not cleared after status");

    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.sts_valid |-> (i_fire && i_last))
        else $error("status without final character");

    a_frozen_no_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_OK) |-> !o_push.rng_valid)
        else $error("range emitted after an error");

endmodule

/* design/brp_out_fifo.sv */
// Four-entry result queue taking up to two results per cycle.
`timescale 1ns / 1ps

module brp_out_fifo
    import brp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_data,
    output logic    o_space
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_result        r_mem [DEPTH];
    logic [AW-1:0]  r_wp, n_wp;
    logic [AW-1:0]  r_rp, n_rp;
    logic [AW:0]    r_count, n_count;
    logic           pop;
    logic [1:0]     push_n;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_space = (r_count <= (AW + 1)'(DEPTH - 2));
    assign pop     = o_valid && !i_stall;
    assign push_n  = 2'(i_push.rng_valid) + 2'(i_push.sts_valid);

    always_comb begin
        n_wp    = r_wp + AW'(push_n);
        n_rp    = r_rp + AW'(pop);
        n_count = r_count + (AW + 1)'(push_n) - (AW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.rng_valid) begin
            r_mem[r_wp] <= i_push.rng;
            if (i_push.sts_valid) begin
                r_mem[r_wp + AW'(1)] <= i_push.sts;
            end
        end else if (i_push.sts_valid) begin
            r_mem[r_wp] <= i_push.sts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW + 1)'(DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_n != 2'd0) |-> (r_count <= (AW + 1)'(DEPTH - 2)))
        else $error("push without two free entries");

endmodule

/* design/http_byte_range_parser.sv */
// Top level of the HTTP byte range parser: input register, parser, result queue.
//
//  Channel   Direction  Handshake          Payload
//  --------  ---------  -----------------  ------------------------------------------
//  input     in         i_valid / o_stall  i_char_code, i_last_char
//  result    out        o_valid / i_stall  o_is_status, o_range_start, o_range_end,
//                                          o_range_size, o_status_code, o_last_result
//  config    in         i_cfg_wr_en        i_cfg_wr_data (max_size)
//
// One item per cycle is accepted while o_stall is low; an item is parsed while it sits in the
// input register, and its results are written into the result queue, which drives the output.
// The four-entry result queue sets the pace: an item is parsed only while two entries
// are free, so a final character can push its range and its status together.
// Reset (synchronous, active low) empties the queue, clears header state and sets
// max_size to 1. o_stall rises only while the input register holds an item that waits
// for queue room; i_stall holds the head result in place.
`timescale 1ns / 1ps

module http_byte_range_parser
    import brp_pkg::*;
#(
    parameter int OFFSET_BITS = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_wr_en,
    input  logic [CFG_W-1:0]   i_cfg_wr_data,
    // input items
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    // result items
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_is_status,
    output logic [RANGE_W-1:0] o_range_start,
    output logic [RANGE_W-1:0] o_range_end,
    output logic [SIZE_W-1:0]  o_range_size,
    output logic [3:0]         o_status_code,
    output logic               o_last_result
);

    logic [CFG_W-1:0] r_max_size;

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_last;

    logic             q_space;
    logic             fire;
    logic             accept;
    t_push            push;
    t_result          head;

    // Parse the held item once the queue can take both of its results.
    assign fire    = r_in_valid && q_space;
    assign o_stall = r_in_valid && !q_space;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            r_max_size <= i_cfg_wr_data;
        end
    end

    // Load a new item on accept; drop the valid when the held one is parsed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_char <= i_char_code;
            r_in_last <= i_last_char;
        end
    end

    brp_parse #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_char     (r_in_char),
        .i_last     (r_in_last),
        .i_max_size (r_max_size),
        .o_push     (push)
    );

    brp_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (head),
        .o_space (q_space)
    );

    assign o_is_status   = head.is_status;
    assign o_range_start = head.range_start;
    assign o_range_end   = head.range_end;
    assign o_range_size  = head.range_size;
    assign o_status_code = head.status_code;
    assign o_last_result = head.last_result;

    a_stall_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid)
        else $error("held item lost while stalled");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the HTTP byte range parser: header stimulus and result checks.
`timescale 1ns / 1ps

module testbench
    import brp_pkg::*;
();

    localparam int TOTAL_W        = 51;
    localparam int ITEM_TARGET    = 1150;
    localparam int MAX_RUN        = 40;     // longest sender gap or receiver stall run
    localparam int SETTLE_CYCLES  = 8;      // pipeline depth plus margin
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [RANGE_W-1:0] OFF_MAX    = {RANGE_W{1'b1}};
    localparam logic [47:0]        PREFIX_TXT = "bytes=";

    // characters used as bad field content
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ONES  = 8'hFF;

    typedef enum {
        HDR_GOOD,
        HDR_BROKEN,
        HDR_LONGNUM,
        HDR_PREFIX,
        HDR_NOISE
    } t_hdr_kind;

    typedef enum {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [CFG_W-1:0]   i_cfg_wr_data;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_char_code;
    logic               i_last_char;
    logic               o_valid;
    logic               i_stall;
    logic               o_is_status;
    logic [RANGE_W-1:0] o_range_start;
    logic [RANGE_W-1:0] o_range_end;
    logic [SIZE_W-1:0]  o_range_size;
    logic [3:0]         o_status_code;
    logic               o_last_result;

    http_byte_range_parser u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Parser state mirrored in the testbench
    logic [RANGE_W-1:0] size_limit;
    int                 pfx_pos;
    t_phase             tok_phase;
    logic [RANGE_W-1:0] start_val;
    logic [RANGE_W-1:0] end_val;
    t_flags             tok_flags;
    t_err               hdr_err;
    logic [TOTAL_W-1:0] byte_total;

    // Ranges and header statuses still owed by the block, oldest first
    t_result pending_parse[$];

    int fail_count  = 0;
    int chars_sent  = 0;
    int send_idle   = 0;
    int stall_pct   = 0;
    int stall_run   = 0;
    int idle_cycles = 0;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] prefix_at(input int p);
        return PREFIX_TXT[8*(5-p) +: 8];
    endfunction

    // Append one decimal digit, saturating at all ones.
    function automatic logic [RANGE_W-1:0] add_digit(input logic [RANGE_W-1:0] acc,
                                                     input logic [7:0] ch);
        logic [RANGE_W-1:0] d;
        d = RANGE_W'(ch) - RANGE_W'(CH_0);
        if (acc > (OFF_MAX - d) / 10) begin
            return OFF_MAX;
        end
        return acc * 10 + d;
    endfunction

    // Queue one expected result behind the ones already owed.
    function automatic void owe_result(input t_result r);
        pending_parse.insert(pending_parse.size(), r);
    endfunction

    task automatic clear_token();
        tok_phase = PH_START;
        start_val = '0;
        end_val   = '0;
        tok_flags = '0;
    endtask

    task automatic clear_header();
        clear_token();
        pfx_pos    = 0;
        hdr_err    = ERR_OK;
        byte_total = '0;
    endtask

    // Close the current token: run the range checks in order and emit the range.
    task automatic close_token();
        logic [RANGE_W-1:0] last_byte;
        logic [SIZE_W-1:0]  span;
        if (tok_flags.nonempty) begin
            if (tok_phase == PH_START) begin
                hdr_err = ERR_NO_DASH;
            end else begin
                // empty end field defaults to size-1, wrapping when size is zero
                last_byte = tok_flags.edigit ? end_val : size_limit - 1'b1;
                if (start_val > last_byte) begin
                    hdr_err = ERR_ORDER;
                end else if (last_byte > size_limit) begin
                    hdr_err = ERR_OVER_MAX;
                end else if (byte_total > TOTAL_W'(size_limit) * TOTAL_W'(3)) begin
                    hdr_err = ERR_TOO_MANY;
                end else begin
                    span       = SIZE_W'(last_byte) - SIZE_W'(start_val) + 1'b1;
                    byte_total = byte_total + TOTAL_W'(span);
                    owe_result(t_result'{is_status: 1'b0,
                                         range_start: start_val,
                                         range_end: last_byte,
                                         range_size: span,
                                         status_code: ERR_OK,
                                         last_result: 1'b0});
                end
            end
        end
        clear_token();
    endtask

    // Advance the mirrored parser by one accepted character.
    task automatic parse_char(input logic [7:0] ch, input logic last);
        logic digit;
        digit = (ch >= CH_0) && (ch <= CH_9);
        if (hdr_err == ERR_OK) begin
            if (pfx_pos < 6) begin
                if (ch == prefix_at(pfx_pos)) begin
                    pfx_pos++;
                end else begin
                    hdr_err = ERR_PREFIX;
                end
            end else if (ch == CH_COMMA) begin
                close_token();
            end else begin
                tok_flags.nonempty = 1'b1;
                if (tok_phase == PH_START) begin
                    if (digit) begin
                        start_val        = add_digit(start_val, ch);
                        tok_flags.sdigit = 1'b1;
                    end else if (ch == CH_DASH) begin
                        // start field errors are only decided at the dash
                        tok_phase = PH_END;
                        if (tok_flags.sbad) begin
                            hdr_err = tok_flags.sbadnodig ? ERR_START_NODIG : ERR_START_BAD;
                        end
                    end else if (!tok_flags.sbad) begin
                        tok_flags.sbad = 1'b1;
                        if (!tok_flags.sdigit) begin
                            tok_flags.sbadnodig = 1'b1;
                        end
                    end
                end else begin
                    if (digit) begin
                        end_val          = add_digit(end_val, ch);
                        tok_flags.edigit = 1'b1;
                    end else begin
                        hdr_err = tok_flags.edigit ? ERR_END_BAD : ERR_END_NODIG;
                    end
                end
            end
            if (last && hdr_err == ERR_OK) begin
                if (pfx_pos < 6) begin
                    hdr_err = ERR_PREFIX;
                end else begin
                    close_token();
                end
            end
        end
        if (last) begin
            owe_result(t_result'{is_status: 1'b1,
                                 range_start: '0,
                                 range_end: '0,
                                 range_size: '0,
                                 status_code: hdr_err,
                                 last_result: 1'b1});
            clear_header();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Pop the oldest expectation on every accepted result and compare it.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_parse.size() == 0) begin
                $error("unexpected result: is_status %0b status_code %0d",
                       o_is_status, o_status_code);
                fail_count++;
            end else begin
                want = pending_parse.pop_front();
                check_field("is_status", want.is_status, o_is_status);
                check_field("range_start", want.range_start, o_range_start);
                check_field("range_end", want.range_end, o_range_end);
                check_field("range_size", want.range_size, o_range_size);
                check_field("status_code", want.status_code, o_status_code);
                check_field("last_result", want.last_result, o_last_result);
            end
        end
    end

    // Count cycles in which neither channel nor the config port moves anything.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver back-pressure: random stalls, runs capped so the watchdog stays sound.
    always @(negedge i_clk) begin
        if (stall_run >= MAX_RUN || $urandom_range(99) >= stall_pct) begin
            i_stall   <= 1'b0;
            stall_run <= 0;
        end else begin
            i_stall   <= 1'b1;
            stall_run <= stall_run + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    task automatic set_idle(input t_idle mode);
        case (mode)
            IDLE_SEND: begin
                send_idle = 86;
                stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle = 0;
                stall_pct = 86;
            end
            IDLE_BOTH: begin
                send_idle = 29;
                stall_pct = 29;
            end
            default: begin
                send_idle = 0;
                stall_pct = 0;
            end
        endcase
    endtask

    // Send one character; hold it until accepted, then predict its results.
    task automatic send_item(input logic [7:0] ch, input logic last);
        int gap;
        gap = 0;
        @(negedge i_clk);
        while (gap < MAX_RUN && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            gap++;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= ch;
        i_last_char <= last;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        parse_char(ch, last);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[i]) begin
            send_item(s[i], i == s.len() - 1);
        end
    endtask

    // Drop valid, wait until every expected result is out, then let the pipe settle.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_parse.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max(input logic [CFG_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        size_limit = value;
    endtask

    // ------------------------------------------------------------------
    // Header generation
    // ------------------------------------------------------------------

    // Append one character to the end of a header under construction.
    function automatic void add_char(ref logic [7:0] q[$], input logic [7:0] ch);
        q.insert(q.size(), ch);
    endfunction

    // Bias numbers toward the edges of the current resource size.
    function automatic logic [RANGE_W-1:0] pick_value(input logic [RANGE_W-1:0] m);
        logic [RANGE_W-1:0] r;
        r = RANGE_W'({$urandom, $urandom});
        case ($urandom_range(7))
            0:       return '0;
            1:       return RANGE_W'($urandom_range(20));
            2:       return m - 1'b1;
            3:       return m;
            4:       return m + 1'b1;
            5, 6:    return (m == '0) ? r : r % m;
            default: return r >> $urandom_range(RANGE_W - 1);
        endcase
    endfunction

    function automatic void push_dec(ref logic [7:0] q[$], input logic [RANGE_W-1:0] v);
        logic [7:0] digits[$];
        int         pad;
        pad = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
        do begin
            digits.push_front(CH_0 + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        repeat (pad) add_char(q, CH_0);
        foreach (digits[i]) begin
            add_char(q, digits[i]);
        end
    endfunction

    // One number field: sometimes empty, sometimes long enough to saturate.
    function automatic void push_field(ref logic [7:0] q[$], input logic [RANGE_W-1:0] m,
                                       input bit long_nums);
        int n;
        if ($urandom_range(5) == 0) begin
            return;
        end
        if (long_nums && $urandom_range(1) == 0) begin
            n = $urandom_range(16, 24);
            repeat (n) add_char(q, CH_0 + 8'($urandom_range(9)));
        end else begin
            push_dec(q, pick_value(m));
        end
    endfunction

    // Any byte that is neither a digit, a comma nor a dash.
    function automatic logic [7:0] bad_char();
        logic [7:0] ch;
        case ($urandom_range(5))
            0: ch = CH_SPACE;
            1: ch = CH_PLUS;
            2: ch = CH_NUL;
            3: ch = CH_ONES;
            default: begin
                do begin
                    ch = 8'($urandom_range(255));
                end while ((ch >= CH_0 && ch <= CH_9) || ch == CH_COMMA || ch == CH_DASH);
            end
        endcase
        return ch;
    endfunction

    function automatic void push_token(ref logic [7:0] q[$], input logic [RANGE_W-1:0] m,
                                       input bit long_nums, input bit corrupt);
        logic [RANGE_W-1:0] s;
        if (!corrupt) begin
            push_field(q, m, long_nums);
            add_char(q, CH_DASH);
            push_field(q, m, long_nums);
            return;
        end
        case ($urandom_range(5))
            0: push_dec(q, pick_value(m));                // token without dash
            1: begin                                      // bad char before any start digit
                add_char(q, bad_char());
                push_field(q, m, 1'b0);
                add_char(q, CH_DASH);
                push_field(q, m, 1'b0);
            end
            2: begin                                      // bad char after start digits
                push_dec(q, pick_value(m));
                add_char(q, bad_char());
                push_field(q, m, 1'b0);
                add_char(q, CH_DASH);
                push_field(q, m, 1'b0);
            end
            3: begin                                      // bad char in end field
                push_field(q, m, 1'b0);
                add_char(q, CH_DASH);
                push_field(q, m, 1'b0);
                add_char(q, bad_char());
            end
            4: begin                                      // extra dash in end field
                push_field(q, m, 1'b0);
                add_char(q, CH_DASH);
                push_dec(q, pick_value(m));
                add_char(q, CH_DASH);
                push_dec(q, pick_value(m));
            end
            default: begin                                // start above end
                s = pick_value(m) | RANGE_W'(1);
                push_dec(q, s);
                add_char(q, CH_DASH);
                push_dec(q, RANGE_W'({$urandom, $urandom}) % s);
            end
        endcase
    endfunction

    function automatic void build_header(ref logic [7:0] q[$], input logic [RANGE_W-1:0] m,
                                         input t_hdr_kind kind);
        int         n;
        int         bad_tok;
        int         k;
        logic [7:0] ch;
        q.delete();
        case (kind)
            HDR_NOISE: begin
                n = $urandom_range(1, 10);
                repeat (n) add_char(q, 8'($urandom_range(255)));
            end
            HDR_PREFIX: begin
                // a truncated prefix, or one with a wrong character
                k = $urandom_range(5);
                for (int i = 0; i < k; i++) begin
                    add_char(q, prefix_at(i));
                end
                if (k == 0 || $urandom_range(1) == 0) begin
                    do begin
                        ch = 8'($urandom_range(255));
                    end while (ch == prefix_at(k));
                    add_char(q, ch);
                    repeat ($urandom_range(4)) add_char(q, 8'($urandom_range(255)));
                end
            end
            default: begin
                for (int i = 0; i < 6; i++) begin
                    add_char(q, prefix_at(i));
                end
                n = $urandom_range(3);
                if ($urandom_range(3) == 0) begin
                    n += $urandom_range(1, 3);
                end
                if (kind == HDR_BROKEN && n == 0) begin
                    n = 1;
                end
                bad_tok = (kind == HDR_BROKEN) ? $urandom_range(n - 1) : -1;
                if ($urandom_range(9) == 0) begin
                    add_char(q, CH_COMMA);
                end
                for (int i = 0; i < n; i++) begin
                    if (i > 0) begin
                        add_char(q, CH_COMMA);
                        if ($urandom_range(9) == 0) begin
                            add_char(q, CH_COMMA);
                        end
                    end
                    push_token(q, m, kind == HDR_LONGNUM, i == bad_tok);
                end
                if ($urandom_range(9) == 0) begin
                    add_char(q, CH_COMMA);
                end
            end
        endcase
    endfunction

    function automatic t_hdr_kind pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 8) begin
            return HDR_NOISE;
        end else if (r < 16) begin
            return HDR_PREFIX;
        end else if (r < 36) begin
            return HDR_BROKEN;
        end else if (r < 44) begin
            return HDR_LONGNUM;
        end
        return HDR_GOOD;
    endfunction

    task automatic send_header(input t_hdr_kind kind);
        logic [7:0] hdr[$];
        build_header(hdr, size_limit, kind);
        foreach (hdr[i]) begin
            send_item(hdr[i], i == hdr.size() - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short fixed headers against the reset size of one byte.
    task automatic test_directed();
        set_idle(IDLE_NONE);
        send_text("b!");            // wrong prefix character
        send_text("bytes=");        // prefix only, empty body is fine
        send_text("bytes=0-,,-");   // explicit and defaulted range around an empty token
        send_item(CH_ONES, 1'b1);   // single all-ones character
        send_item(CH_NUL, 1'b1);    // single NUL character
    endtask

    task automatic test_prefix_errors();
        set_idle(IDLE_BOTH);
        repeat (14) send_header(HDR_PREFIX);
        repeat (4) send_header(HDR_NOISE);
    endtask

    // Broken tokens on a small resource, then good headers that run out of total.
    task automatic test_field_errors();
        set_max(RANGE_W'($urandom_range(2, 12)));
        set_idle(IDLE_RECV);
        repeat (16) send_header(HDR_BROKEN);
        set_max(RANGE_W'(3));
        repeat (8) send_header(HDR_GOOD);
    endtask

    // Largest resource with digit strings long enough to saturate.
    task automatic test_saturation();
        set_max(OFF_MAX);
        set_idle(IDLE_SEND);
        repeat (6) send_header(HDR_LONGNUM);
    endtask

    // Zero size: the default end wraps to all ones.
    task automatic test_zero_size();
        set_max('0);
        set_idle(IDLE_NONE);
        repeat (8) send_header(pick_kind());
    endtask

    // Mixed headers, rotating the idle pattern and the resource size.
    task automatic test_random();
        int round;
        int stop_at;
        round = 0;
        while (chars_sent < ITEM_TARGET) begin
            case (round % 5)
                0:       set_max(RANGE_W'(1));
                1:       set_max(OFF_MAX);
                2:       set_max(RANGE_W'($urandom_range(2, 40)));
                3:       set_max(RANGE_W'({$urandom, $urandom}) >> $urandom_range(RANGE_W - 1));
                default: set_max(RANGE_W'($urandom_range(1000, 100000)));
            endcase
            set_idle(t_idle'(round % 4));
            stop_at = chars_sent + 100;
            while (chars_sent < stop_at && chars_sent < ITEM_TARGET) begin
                send_header(pick_kind());
            end
            round++;
        end
    endtask

    initial begin
        // hold every input at a known value through reset
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_char_code   = '0;
        i_last_char   = 1'b0;
        i_stall       = 1'b0;
        size_limit    = RANGE_W'(1);
        clear_header();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_prefix_errors();
        test_field_errors();
        test_saturation();
        test_zero_size();
        test_random();

        // wait out every owed result, then the pipeline tail
        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* http_byte_range_parser.f */
design/brp_pkg.sv
design/brp_parse.sv
design/brp_out_fifo.sv
design/http_byte_range_parser.sv
tb/sv/testbench.sv
